@@ hdl/dfpa_pkg.sv @@
package dfpa_pkg;

  // Number format
  localparam logic [19:0] FRAC_SCALE = 20'd1000000;
  localparam logic [31:0] WHOLE_MAX  = 32'd2147483647;
  // 10^19 / den / 10^7 folds into 10^12 / den
  localparam logic [51:0] RECIP_NUM  = 52'd1000000000000;

  // Default depth of the front-to-back job queue
  localparam int QUEUE_DEPTH = 4;

  // Operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Job kinds picked by the front end
  typedef enum logic [2:0] {
    K_ADDSUB,
    K_MUL,
    K_DIVZ,
    K_DINT,
    K_DFRAC,
    K_DBYF,
    K_DRECIP
  } dfpa_kind_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        a_sign;
    logic [30:0] a_whole;
    logic [19:0] a_frac;
    logic        b_sign;
    logic [30:0] b_whole;
    logic [19:0] b_frac;
  } dfpa_in_t;

  typedef struct packed {
    logic        result_sign;
    logic [30:0] result_whole;
    logic [19:0] result_frac;
    logic [1:0]  status;
  } dfpa_out_t;

  // Classified job handed from front to back
  typedef struct packed {
    dfpa_kind_t  kind;
    logic        sign;
    logic [51:0] num;
    logic [50:0] den;
    logic [30:0] aw;
    logic [19:0] af;
    logic [30:0] bw;
    logic [19:0] bf;
  } dfpa_job_t;

endpackage

@@ hdl/dfpa_div.sv @@
module dfpa_div #(
  parameter int NW = 52,
  parameter int DW = 51,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] side_o
);

  // Restoring divider, one quotient bit per stage, MSB first
  logic [NW:0]   vld_w;
  logic [DW-1:0] rem_w  [NW+1];
  logic [NW-1:0] num_w  [NW+1];
  logic [NW-1:0] quo_w  [NW+1];
  logic [DW-1:0] den_w  [NW+1];
  logic [PW-1:0] side_w [NW+1];

  assign vld_w[0]  = vld_i;
  assign rem_w[0]  = '0;
  assign num_w[0]  = num_i;
  assign quo_w[0]  = '0;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_nxt;
    logic          vld_r;
    logic [DW-1:0] rem_r;
    logic [NW-1:0] num_r;
    logic [NW-1:0] quo_r;
    logic [DW-1:0] den_r;
    logic [PW-1:0] side_r;

    // shift in next dividend bit, subtract if it fits
    always_comb begin
      trial   = {rem_w[k], num_w[k][NW-1]};
      fits    = (trial >= {1'b0, den_w[k]});
      rem_nxt = fits ? DW'(trial - {1'b0, den_w[k]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        num_r  <= {num_w[k][NW-2:0], 1'b0};
        quo_r  <= {quo_w[k][NW-2:0], fits};
        den_r  <= den_w[k];
        side_r <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_r;
    assign rem_w[k+1]  = rem_r;
    assign num_w[k+1]  = num_r;
    assign quo_w[k+1]  = quo_r;
    assign den_w[k+1]  = den_r;
    assign side_w[k+1] = side_r;
  end

  assign vld_o  = vld_w[NW];
  assign quo_o  = quo_w[NW];
  assign rem_o  = rem_w[NW];
  assign side_o = side_w[NW];

endmodule

// Divide by 10^6 in two stages: x / 10^6 = (x >> 6) / 15625, and the
// divide by 15625 is a multiply by a rounded-up reciprocal, exact for
// every shifted dividend of YW bits. Quotient only.
module dfpa_div_scale #(
  parameter int NW = 53,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [PW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-20:0] quo_o,
  output logic [PW-1:0] side_o
);

  localparam int YW  = NW - 6;
  localparam int SH  = YW + 14;
  localparam int MW  = YW + 1;
  localparam int LW  = 24;
  localparam int YHW = YW - LW;
  localparam int MHW = MW - LW;
  localparam int PRW = YW + MW;
  localparam logic [63:0]    RECIP    = ((64'd1 << SH) / 64'd15625) + 64'd1;
  localparam logic [LW-1:0]  RECIP_LO = RECIP[LW-1:0];
  localparam logic [MHW-1:0] RECIP_HI = RECIP[MW-1:LW];

  logic [YW-1:0]        y;
  logic [2*LW-1:0]      pp_ll_nxt, pp_ll_r;
  logic [LW+MHW-1:0]    pp_lh_nxt, pp_lh_r;
  logic [YHW+LW-1:0]    pp_hl_nxt, pp_hl_r;
  logic [YHW+MHW-1:0]   pp_hh_nxt, pp_hh_r;
  logic                 s1_vld_r;
  logic [PW-1:0]        s1_side_r;
  logic [PRW-1:0]       prod;
  logic [NW-20:0]       quo_nxt, quo_r;
  logic                 s2_vld_r;
  logic [PW-1:0]        s2_side_r;

  // stage 1: partial products on 24-bit limbs
  always_comb begin
    y         = num_i[NW-1:6];
    pp_ll_nxt = y[LW-1:0] * RECIP_LO;
    pp_lh_nxt = y[LW-1:0] * RECIP_HI;
    pp_hl_nxt = y[YW-1:LW] * RECIP_LO;
    pp_hh_nxt = y[YW-1:LW] * RECIP_HI;
  end

  // stage 2: sum and drop the reciprocal's fraction bits
  always_comb begin
    prod    = {pp_hh_r, {(2*LW){1'b0}}} + PRW'({pp_lh_r, {LW{1'b0}}}) +
              PRW'({pp_hl_r, {LW{1'b0}}}) + PRW'(pp_ll_r);
    quo_nxt = prod[PRW-1:SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r   <= pp_ll_nxt;
      pp_lh_r   <= pp_lh_nxt;
      pp_hl_r   <= pp_hl_nxt;
      pp_hh_r   <= pp_hh_nxt;
      s1_side_r <= side_i;
      quo_r     <= quo_nxt;
      s2_side_r <= s1_side_r;
    end
  end

  assign vld_o  = s2_vld_r;
  assign quo_o  = quo_r;
  assign side_o = s2_side_r;

endmodule

@@ hdl/dfpa_queue.sv @@
module dfpa_queue #(
  parameter int DEPTH = dfpa_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dfpa_pkg::dfpa_job_t wdata,
  input  logic                pop,
  output dfpa_pkg::dfpa_job_t rdata,
  output logic                full,
  output logic                empty
);
  import dfpa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dfpa_job_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/dfpa_front.sv @@
module dfpa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfpa_pkg::dfpa_in_t  in_data,
  input  logic                q_full,
  output logic                push,
  output dfpa_pkg::dfpa_job_t job
);
  import dfpa_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic        as;
    logic [30:0] aw;
    logic [19:0] af;
    logic        bs;
    logic [30:0] bw;
    logic [19:0] bf;
    logic [50:0] msa;
    logic [50:0] msb;
    logic [39:0] maf;
  } f1_t;

  typedef struct packed {
    dfpa_kind_t  kind;
    logic        as;
    logic        sb;
    logic        psign;
    logic [30:0] aw;
    logic [19:0] af;
    logic [30:0] bw;
    logic [19:0] bf;
    logic [50:0] msa;
    logic [39:0] maf;
    logic [51:0] ma;
    logic [51:0] mb;
  } f2_t;

  logic adv;
  logic f1_vld_r, f2_vld_r;
  f1_t  f1_r, f1_nxt;
  f2_t  f2_r, f2_nxt;

  assign adv      = !q_full;
  assign in_ready = adv;
  assign push     = adv && f2_vld_r;

  // stage 1: scale whole parts, and a's fraction, by 10^6
  always_comb begin
    f1_nxt.mode = in_data.mode;
    f1_nxt.as   = in_data.a_sign;
    f1_nxt.aw   = in_data.a_whole;
    f1_nxt.af   = in_data.a_frac;
    f1_nxt.bs   = in_data.b_sign;
    f1_nxt.bw   = in_data.b_whole;
    f1_nxt.bf   = in_data.b_frac;
    f1_nxt.msa  = in_data.a_whole * FRAC_SCALE;
    f1_nxt.msb  = in_data.b_whole * FRAC_SCALE;
    f1_nxt.maf  = in_data.a_frac * FRAC_SCALE;
  end

  // stage 2: scaled values and job kind
  always_comb begin
    f2_nxt.as    = f1_r.as;
    f2_nxt.sb    = (f1_r.mode == MODE_SUB) ? ~f1_r.bs : f1_r.bs;
    f2_nxt.psign = f1_r.as ^ f1_r.bs;
    f2_nxt.aw    = f1_r.aw;
    f2_nxt.af    = f1_r.af;
    f2_nxt.bw    = f1_r.bw;
    f2_nxt.bf    = f1_r.bf;
    f2_nxt.msa   = f1_r.msa;
    f2_nxt.maf   = f1_r.maf;
    f2_nxt.ma    = 52'(f1_r.msa) + 52'(f1_r.af);
    f2_nxt.mb    = 52'(f1_r.msb) + 52'(f1_r.bf);
    if (f1_r.mode == MODE_ADD || f1_r.mode == MODE_SUB) begin
      f2_nxt.kind = K_ADDSUB;
    end else if (f1_r.mode == MODE_MUL) begin
      f2_nxt.kind = K_MUL;
    end else if (f1_r.bw == '0 && f1_r.bf == '0) begin
      f2_nxt.kind = K_DIVZ;
    end else if (f1_r.af == '0 && f1_r.bf == '0 && f1_r.aw != '0 && f1_r.bw != '0) begin
      f2_nxt.kind = K_DINT;
    end else if (f1_r.aw == '0 && f1_r.bw == '0 && f1_r.af != '0 && f1_r.bf != '0) begin
      f2_nxt.kind = K_DFRAC;
    end else if (f1_r.bw == '0) begin
      f2_nxt.kind = K_DBYF;
    end else begin
      f2_nxt.kind = K_DRECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  // stage 3: signed add/subtract and divider operands
  logic [51:0] sum;
  logic [52:0] diff;
  logic [51:0] mag;
  logic        asign;

  always_comb begin
    sum  = f2_r.ma + f2_r.mb;
    diff = {1'b0, f2_r.ma} - {1'b0, f2_r.mb};
    if (f2_r.as == f2_r.sb) begin
      mag   = sum;
      asign = f2_r.as;
    end else if (!diff[52]) begin
      mag   = diff[51:0];
      asign = f2_r.as;
    end else begin
      mag   = f2_r.mb - f2_r.ma;
      asign = f2_r.sb;
    end
    if (mag == '0) begin
      asign = 1'b0;
    end

    job.kind = f2_r.kind;
    job.sign = f2_r.psign;
    job.aw   = f2_r.aw;
    job.af   = f2_r.af;
    job.bw   = f2_r.bw;
    job.bf   = f2_r.bf;
    job.num  = '0;
    job.den  = 51'd1;
    case (f2_r.kind)
      K_ADDSUB: begin
        job.sign = asign;
        job.num  = mag;
        job.den  = 51'(FRAC_SCALE);
      end
      K_DIVZ: begin
        job.sign = 1'b0;
      end
      K_DINT: begin
        job.num = 52'(f2_r.msa);
        job.den = 51'(f2_r.bw);
      end
      K_DFRAC: begin
        job.num = 52'(f2_r.maf);
        job.den = 51'(f2_r.bf);
      end
      K_DBYF: begin
        job.num = f2_r.ma;
        job.den = 51'(f2_r.bf);
      end
      K_DRECIP: begin
        job.num = RECIP_NUM;
        job.den = f2_r.mb[50:0];
      end
      default: begin
        job.num = '0;
      end
    endcase
  end

endmodule

@@ hdl/dfpa_back.sv @@
module dfpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  dfpa_pkg::dfpa_job_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output dfpa_pkg::dfpa_out_t out_data
);
  import dfpa_pkg::*;

  typedef struct packed {
    dfpa_kind_t  kind;
    logic        sign;
    logic [30:0] aw;
    logic [19:0] af;
    logic [30:0] bw;
    logic [19:0] bf;
  } d1_side_t;

  typedef struct packed {
    dfpa_kind_t  kind;
    logic        sign;
    logic [61:0] up;
    logic [50:0] t1;
    logic [50:0] t2;
    logic [51:0] q1;
    logic [19:0] r1f;
  } d2_side_t;

  typedef struct packed {
    d2_side_t    sd;
    logic [39:0] p3;
  } p1_t;

  typedef struct packed {
    dfpa_kind_t  kind;
    logic        sign;
    logic [61:0] up;
    logic [51:0] q1;
    logic [19:0] r1f;
    logic [19:0] lo;
  } d3_side_t;

  typedef struct packed {
    d3_side_t    sd;
    logic [52:0] n3;
  } s_t;

  logic      adv;
  logic      out_vld_r;
  dfpa_out_t out_r, out_nxt;

  // whole back end moves together when the output register frees up
  assign adv       = !out_vld_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // first divider: add/sub split, integer and fraction divides, reciprocal
  d1_side_t    d1_in, d1_out;
  logic        d1_vld;
  logic [51:0] q1;
  logic [50:0] r1;

  always_comb begin
    d1_in.kind = q_data.kind;
    d1_in.sign = q_data.sign;
    d1_in.aw   = q_data.aw;
    d1_in.af   = q_data.af;
    d1_in.bw   = q_data.bw;
    d1_in.bf   = q_data.bf;
  end

  dfpa_div #(.NW(52), .DW(51), .PW($bits(d1_side_t))) u_div1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (!q_empty),
    .num_i  (q_data.num),
    .den_i  (q_data.den),
    .side_i (d1_in),
    .vld_o  (d1_vld),
    .quo_o  (q1),
    .rem_o  (r1),
    .side_o (d1_out)
  );

  // partial products of the multiply
  logic        p1_vld_r;
  p1_t         p1_r, p1_nxt;
  logic        rec_one;
  logic [30:0] pw;
  logic [19:0] pf;

  always_comb begin
    rec_one = (q1 == 52'(FRAC_SCALE));
    if (d1_out.kind == K_DRECIP) begin
      pw = rec_one ? 31'd1 : 31'd0;
      pf = rec_one ? 20'd0 : q1[19:0];
    end else begin
      pw = d1_out.bw;
      pf = d1_out.bf;
    end
    p1_nxt.sd.kind = d1_out.kind;
    p1_nxt.sd.sign = d1_out.sign;
    p1_nxt.sd.up   = d1_out.aw * pw;
    p1_nxt.sd.t1   = d1_out.aw * pf;
    p1_nxt.sd.t2   = pw * d1_out.af;
    p1_nxt.sd.q1   = q1;
    p1_nxt.sd.r1f  = r1[19:0];
    p1_nxt.p3      = d1_out.af * pf;
  end

  // second divider: fraction-by-fraction product over 10^6
  logic        d2_vld;
  logic [20:0] q2;
  d2_side_t    d2_out;

  dfpa_div_scale #(.NW(40), .PW($bits(d2_side_t))) u_div2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (p1_vld_r),
    .num_i  (p1_r.p3),
    .side_i (p1_r.sd),
    .vld_o  (d2_vld),
    .quo_o  (q2),
    .side_o (d2_out)
  );

  // sum of the fraction terms, or quotient to be split
  logic s_vld_r;
  s_t   s_r, s_nxt;
  logic [52:0] fr;

  always_comb begin
    fr            = 53'(d2_out.t1) + 53'(d2_out.t2) + 53'(q2);
    s_nxt.sd.kind = d2_out.kind;
    s_nxt.sd.sign = d2_out.sign;
    s_nxt.sd.up   = d2_out.up;
    s_nxt.sd.q1   = d2_out.q1;
    s_nxt.sd.r1f  = d2_out.r1f;
    if (d2_out.kind == K_MUL || d2_out.kind == K_DRECIP) begin
      s_nxt.n3 = fr;
    end else begin
      s_nxt.n3 = 53'(d2_out.q1);
    end
    s_nxt.sd.lo   = s_nxt.n3[19:0];
  end

  // third divider: split into whole and millionths
  logic        d3_vld;
  logic [33:0] q3;
  logic [19:0] r3;
  d3_side_t    d3_out;

  dfpa_div_scale #(.NW(53), .PW($bits(d3_side_t))) u_div3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (s_vld_r),
    .num_i  (s_r.n3),
    .side_i (s_r.sd),
    .vld_o  (d3_vld),
    .quo_o  (q3),
    .side_o (d3_out)
  );

  // result pick and saturation
  logic [63:0] w;
  logic [19:0] f;
  logic [1:0]  st;
  logic        sg;

  always_comb begin
    // remainder is below 10^6, so the low 20 bits carry it exactly
    r3 = d3_out.lo - 20'(q3[19:0] * FRAC_SCALE);
    st = ST_OK;
    sg = d3_out.sign;
    case (d3_out.kind)
      K_ADDSUB: begin
        w = 64'(d3_out.q1);
        f = d3_out.r1f;
      end
      K_MUL, K_DRECIP: begin
        w = 64'(d3_out.up) + 64'(q3);
        f = r3;
      end
      K_DINT, K_DFRAC: begin
        w = 64'(q3);
        f = r3;
      end
      K_DBYF: begin
        w = 64'(d3_out.q1);
        f = '0;
      end
      default: begin
        st = ST_DIVZ;
        sg = 1'b0;
        w  = '0;
        f  = '0;
      end
    endcase
    if (st == ST_OK && w > 64'(WHOLE_MAX)) begin
      w  = 64'(WHOLE_MAX);
      f  = FRAC_SCALE - 20'd1;
      st = ST_SAT;
    end
    out_nxt.result_sign  = sg;
    out_nxt.result_whole = w[30:0];
    out_nxt.result_frac  = f;
    out_nxt.status       = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      s_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r  <= d1_vld;
      s_vld_r   <= d2_vld;
      out_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      s_r   <= s_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

@@ hdl/decimal_fixed_point_alu_unit.sv @@
// Channel   Ports                              Payload
// input     in_valid / in_ready / in_data      dfpa_in_t  (mode, operands a and b)
// result    out_valid / out_ready / out_data   dfpa_out_t (sign, whole, frac, status)
//
// One operation per cycle sustained while results are taken; each one result, in order.
// From input transfer to out_valid a result passes two front stages, one
// in the queue, a 52-stage bit-per-stage divider, two 2-stage divide-by-10^6
// units (reciprocal multiply) and three registers.
// Reset (rst_n, synchronous) empties every stage and the queue.
// A stalled result holds the back end; the queue lets the front keep going until it fills.
module decimal_fixed_point_alu_unit #(
  parameter int QDEPTH = dfpa_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfpa_pkg::dfpa_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dfpa_pkg::dfpa_out_t out_data
);
  import dfpa_pkg::*;

  logic      push, pop, q_full, q_empty;
  dfpa_job_t job_w, job_r;

  dfpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (job_w)
  );

  dfpa_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_w),
    .pop   (pop),
    .rdata (job_r),
    .full  (q_full),
    .empty (q_empty)
  );

  dfpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (job_r),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // divide by zero reports an all-zero value
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DIVZ |->
      !out_data.result_sign && out_data.result_whole == '0 && out_data.result_frac == '0)
    else $error("divide by zero result not cleared");

  // fraction always normalized
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_frac < FRAC_SCALE)
    else $error("result fraction out of range");

  // saturation pins the magnitude to the maximum
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_SAT |->
      out_data.result_whole == WHOLE_MAX[30:0] &&
      out_data.result_frac == FRAC_SCALE - 20'd1)
    else $error("saturated result has wrong value");

endmodule

@@ test/decimal_fixed_point_alu_unit_tb.sv @@
`timescale 1ns / 1ps

module decimal_fixed_point_alu_unit_tb;
  import dfpa_pkg::*;

  localparam int LATENCY = 160;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [63:0] SCALE = 64'd1000000;
  localparam logic [63:0] WMAX = 64'd2147483647;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dfpa_in_t in_data;
  logic out_valid;
  logic out_ready;
  dfpa_out_t out_data;

  dfpa_in_t op_queue[$];
  dfpa_out_t result_queue[$];
  int errors;
  int idle_cycles;
  bit stim_done;
  bit hold_off;
  bit in_fire;
  int burst_left;
  int gap_left;

  decimal_fixed_point_alu_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Whole and fraction of a product of two decimal numbers
  function automatic void mul_parts(input logic [63:0] aw, af, bw, bf,
                                    output logic [63:0] w, f);
    logic [63:0] fr;
    fr = aw * bf + bw * af + (af * bf) / SCALE;
    w = aw * bw + fr / SCALE;
    f = fr % SCALE;
  endfunction

  // Expected result of one operation
  function automatic dfpa_out_t alu_result(input dfpa_in_t op);
    logic [63:0] aw, af, bw, bf, ma, mb, mag, w, f, q, den, rec;
    logic sb, sgn;
    logic [1:0] st;
    dfpa_out_t r;
    aw = op.a_whole; af = op.a_frac; bw = op.b_whole; bf = op.b_frac;
    st = ST_OK;
    sgn = op.a_sign ^ op.b_sign;
    if (op.mode == MODE_ADD || op.mode == MODE_SUB) begin
      ma = aw * SCALE + af;
      mb = bw * SCALE + bf;
      sb = (op.mode == MODE_SUB) ? ~op.b_sign : op.b_sign;
      if (op.a_sign == sb) begin
        mag = ma + mb; sgn = op.a_sign;
      end else if (ma >= mb) begin
        mag = ma - mb; sgn = op.a_sign;
      end else begin
        mag = mb - ma; sgn = sb;
      end
      if (mag == 0) sgn = 1'b0;
      w = mag / SCALE; f = mag % SCALE;
    end else if (op.mode == MODE_MUL) begin
      mul_parts(aw, af, bw, bf, w, f);
    end else if (bw == 0 && bf == 0) begin
      sgn = 1'b0; w = 0; f = 0; st = ST_DIVZ;
    end else if (af == 0 && bf == 0 && aw != 0 && bw != 0) begin
      q = (aw * SCALE) / bw; w = q / SCALE; f = q % SCALE;
    end else if (aw == 0 && bw == 0 && af != 0 && bf != 0) begin
      q = (af * SCALE) / bf; w = q / SCALE; f = q % SCALE;
    end else if (bw == 0) begin
      w = (aw * SCALE + af) / bf; f = 0;
    end else begin
      den = bw * SCALE + bf;
      rec = (64'd10000000000000000000 / den) / 64'd10000000;
      mul_parts(aw, af, rec / SCALE, rec % SCALE, w, f);
    end
    if (st == ST_OK && w > WMAX) begin
      w = WMAX; f = SCALE - 1; st = ST_SAT;
    end
    r.result_sign = sgn;
    r.result_whole = w[30:0];
    r.result_frac = f[19:0];
    r.status = st;
    return r;
  endfunction

  function automatic logic [19:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'd999999;
      2: return 20'hFFFFF;
      3: return 20'($urandom_range(1000000, 1048575));
      default: return 20'($urandom_range(0, 999999));
    endcase
  endfunction

  function automatic logic [30:0] rand_whole();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(0, 9));
      3: return 31'($urandom);
      4: return 31'($urandom_range(0, 99999));
      default: return 31'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic dfpa_in_t make_op(input logic [1:0] md,
      input logic as, input logic [30:0] aw, input logic [19:0] af,
      input logic bs, input logic [30:0] bw, input logic [19:0] bf);
    dfpa_in_t op;
    op.mode = md; op.a_sign = as; op.a_whole = aw; op.a_frac = af;
    op.b_sign = bs; op.b_whole = bw; op.b_frac = bf;
    return op;
  endfunction

  // Stimulus: directed corners first, then random operations
  initial begin
    dfpa_in_t op;
    op_queue.push_back(make_op(MODE_ADD, 1'b0, 31'd0, 20'd0, 1'b0, 31'd0, 20'd0));
    op_queue.push_back(make_op(MODE_ADD, 1'b0, 31'h7FFFFFFF, 20'd999999, 1'b0,
                               31'h7FFFFFFF, 20'd999999));
    op_queue.push_back(make_op(MODE_ADD, 1'b1, 31'd5, 20'd250000, 1'b0, 31'd5,
                               20'd250000));
    op_queue.push_back(make_op(MODE_ADD, 1'b1, 31'd3, 20'd0, 1'b0, 31'd7, 20'd500000));
    op_queue.push_back(make_op(MODE_SUB, 1'b0, 31'd7, 20'd1, 1'b0, 31'd7, 20'd1));
    op_queue.push_back(make_op(MODE_SUB, 1'b1, 31'h7FFFFFFF, 20'hFFFFF, 1'b0,
                               31'h7FFFFFFF, 20'hFFFFF));
    op_queue.push_back(make_op(MODE_SUB, 1'b0, 31'd1, 20'd0, 1'b1, 31'd2, 20'd0));
    op_queue.push_back(make_op(MODE_MUL, 1'b1, 31'd0, 20'd0, 1'b0, 31'd9, 20'd5));
    op_queue.push_back(make_op(MODE_MUL, 1'b0, 31'd65536, 20'd0, 1'b1, 31'd65536, 20'd0));
    op_queue.push_back(make_op(MODE_MUL, 1'b1, 31'd12, 20'd345678, 1'b1, 31'd3,
                               20'd999999));
    op_queue.push_back(make_op(MODE_MUL, 1'b0, 31'h7FFFFFFF, 20'hFFFFF, 1'b0,
                               31'h7FFFFFFF, 20'hFFFFF));
    op_queue.push_back(make_op(MODE_DIV, 1'b1, 31'd5, 20'd5, 1'b0, 31'd0, 20'd0));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'd22, 20'd0, 1'b1, 31'd7, 20'd0));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'd0, 20'd123456, 1'b0, 31'd0, 20'd7));
    op_queue.push_back(make_op(MODE_DIV, 1'b1, 31'd100, 20'd3, 1'b0, 31'd0, 20'd1));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'h7FFFFFFF, 20'hFFFFF, 1'b0, 31'd0,
                               20'd1));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'd10, 20'd500000, 1'b1, 31'd3,
                               20'd250000));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'd0, 20'd0, 1'b0, 31'd4, 20'd0));
    op_queue.push_back(make_op(MODE_DIV, 1'b1, 31'h7FFFFFFF, 20'd999999, 1'b1,
                               31'h7FFFFFFF, 20'hFFFFF));
    op_queue.push_back(make_op(MODE_DIV, 1'b0, 31'd1, 20'd0, 1'b0, 31'd0, 20'hFFFFF));
    repeat (400) begin
      op.mode = 2'($urandom_range(0, 3));
      op.a_sign = 1'($urandom);
      op.b_sign = 1'($urandom);
      op.a_whole = rand_whole();
      op.b_whole = rand_whole();
      op.a_frac = rand_frac();
      op.b_frac = rand_frac();
      // now and then pure fractions for the fraction divide branches
      if (op.mode == MODE_DIV && $urandom_range(0, 5) == 0) begin
        op.a_whole = '0; op.b_whole = '0;
      end
      op_queue.push_back(op);
    end
    stim_done = 1'b1;
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Input transfer seen at the last rising edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  // Driver: bursts and gaps, inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= $urandom_range(1, 30);
      gap_left <= 0;
    end else if (in_valid && !in_fire) begin
      // hold the pending transfer
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (op_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= op_queue.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, with one long hold-off early on
  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (($time / 2000) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    dfpa_out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        result_queue.push_back(alu_result(in_data));
      end
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = result_queue.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // End of run and watchdog
  initial begin
    errors = 0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done && op_queue.size() == 0 && !in_valid);
        wait (result_queue.size() == 0);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && result_queue.size() == 0)
          $display("decimal_fixed_point_alu_unit_tb: PASS");
        else
          $display("decimal_fixed_point_alu_unit_tb: FAIL");
        $finish;
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("decimal_fixed_point_alu_unit_tb: FAIL");
        $finish;
      end
    join
  end

endmodule
